// File: sv/prp_pkg.sv
// Shared types and constants of the point rotate and project block.
// Field widths, register indexes and the coefficient sweep states.
// No dependencies; every other file of the block imports this package.
package prp_pkg;

    // Field widths of the input and result items.
    localparam int MAP_W = 10;
    localparam int Z_W = 16;
    localparam int OUT_W = 22;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    // Configuration register widths.
    localparam int ZOOM_W = 8;
    localparam int ZZOOM_W = 16;
    localparam int ANG_W = 10;
    localparam int ANGLES_W = 30;
    localparam int CTR_W = 18;
    localparam int SCR_W = 20;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Every angle index has its own table entry.
    localparam int ANGLE_DEPTH = 1 << ANG_W;

    // Working width of a coordinate after scaling and rotation.
    localparam int CW = 28;

    // Width of the scaled height product.
    localparam int ZP_W = Z_W + ZZOOM_W + 1;

    // Largest result value before saturation.
    localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_ZOOM,
        REG_Z_ZOOM,
        REG_ANGLES,
        REG_ISO_MODE,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_SCREEN_X,
        REG_SCREEN_Y
    } reg_index_t;

    // Sweep that loads the sine and cosine of each axis.
    typedef enum logic [2:0] {
        TRIG_READ_X,
        TRIG_READ_Y,
        TRIG_READ_Z,
        TRIG_LAST,
        TRIG_DONE
    } trig_state_t;

endpackage

// File: sv/point_rotate_project.sv
// Point rotate and project: screen position of one wireframe map point per item.
//
// Usage: software writes zoom, height scale, the three angle indices, the
// projection mode, the map center and the screen shifts through the APB port
// while no item is in flight. Map points enter on the s_ stream, one item per
// clock while s_tready is high, and each gives exactly one result item on the
// m_ stream with screen x, screen y and depth, saturated to 22 bits signed.
// An accepted item reaches m_tvalid through two scale stages, two stages for each
// of the three axis rotations and four projection stages. The pipeline moves one
// item per cycle while the receiver takes results; each stage has its own valid
// bit and takes a new item whenever it is empty or its item moves on, so a
// stalled receiver only holds back what is behind the output register and
// nothing is lost. After reset, and after every write to the angle register, the
// sine and cosine of each axis are read from the tables in the states TRIG_READ_X
// to TRIG_LAST, one axis per table read; s_tready stays low during that reload.
// Reset clears all pipeline valid bits and sets the registers to their defaults.
module point_rotate_project #(
    parameter int SINE_STEPS = 1024,
    parameter int FRACTION_BITS = 14
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [prp_pkg::S_DATA_W-1:0]       s_tdata,   // map_x, map_y, map_z
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [prp_pkg::M_DATA_W-1:0]       m_tdata,   // out_x, out_y, out_z
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prp_pkg::APB_AW-1:0]         paddr,
    input  logic [prp_pkg::APB_DW-1:0]         pwdata,
    output logic [prp_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import prp_pkg::*;

    localparam int CFW = FRACTION_BITS + 2;

    // Configuration registers.
    logic [ZOOM_W-1:0] zoom_reg;
    logic [ZZOOM_W-1:0] z_zoom_reg;
    logic [ANGLES_W-1:0] angles_reg;
    logic iso_mode_reg;
    logic [CTR_W-1:0] center_x_reg, center_y_reg;
    logic signed [SCR_W-1:0] screen_x_reg, screen_y_reg;
    logic cfg_wr, angles_wr;
    reg_index_t cfg_idx;

    // Pipeline signals.
    logic coef_ready;
    logic signed [CFW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
    logic [MAP_W-1:0] in_map_x, in_map_y;
    logic signed [Z_W-1:0] in_map_z;
    logic a_valid_reg, b_valid_reg, a_ready, b_ready, s_accept;
    logic [MAP_W+ZOOM_W-1:0] xa_reg, ya_reg;
    logic signed [ZP_W-1:0] za_reg, z_bias;
    logic signed [CW-1:0] xb_reg, yb_reg, zb_reg;
    logic signed [CW-1:0] xa_ext, ya_ext, cx_ext, cy_ext;
    logic rx_in_ready, rx_valid, ry_ready, ry_valid, rz_ready, rz_valid, pj_ready;
    logic signed [CW-1:0] rx_y, rx_z, rx_x, ry_z, ry_x, ry_y, rz_x, rz_y, rz_z;
    logic [OUT_W-1:0] out_x, out_y, out_z;

    // Configuration writes.
    assign pready = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[APB_AW-1:2]);
    assign cfg_wr = psel && penable && pwrite;
    assign angles_wr = cfg_wr && (cfg_idx == REG_ANGLES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg <= ZOOM_W'(1);
            z_zoom_reg <= ZZOOM_W'(256);
            angles_reg <= '0;
            iso_mode_reg <= 1'b1;
            center_x_reg <= '0;
            center_y_reg <= '0;
            screen_x_reg <= '0;
            screen_y_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ZOOM: zoom_reg <= pwdata[ZOOM_W-1:0];
                REG_Z_ZOOM: z_zoom_reg <= pwdata[ZZOOM_W-1:0];
                REG_ANGLES: angles_reg <= pwdata[ANGLES_W-1:0];
                REG_ISO_MODE: iso_mode_reg <= pwdata[0];
                REG_CENTER_X: center_x_reg <= pwdata[CTR_W-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[CTR_W-1:0];
                REG_SCREEN_X: screen_x_reg <= pwdata[SCR_W-1:0];
                REG_SCREEN_Y: screen_y_reg <= pwdata[SCR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (cfg_idx)
            REG_ZOOM: prdata = APB_DW'(zoom_reg);
            REG_Z_ZOOM: prdata = APB_DW'(z_zoom_reg);
            REG_ANGLES: prdata = APB_DW'(angles_reg);
            REG_ISO_MODE: prdata = APB_DW'(iso_mode_reg);
            REG_CENTER_X: prdata = APB_DW'(center_x_reg);
            REG_CENTER_Y: prdata = APB_DW'(center_y_reg);
            REG_SCREEN_X: prdata = APB_DW'(unsigned'(screen_x_reg));
            REG_SCREEN_Y: prdata = APB_DW'(unsigned'(screen_y_reg));
            default: prdata = '0;
        endcase
    end

    // Axis coefficients.
    prp_trig #(
        .SINE_STEPS(SINE_STEPS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_trig (
        .aclk(aclk),
        .aresetn(aresetn),
        .angles(angles_reg),
        .angles_wr(angles_wr),
        .coef_ready(coef_ready),
        .sin_x(sin_x),
        .cos_x(cos_x),
        .sin_y(sin_y),
        .cos_y(cos_y),
        .sin_z(sin_z),
        .cos_z(cos_z)
    );

    // Input fields.
    assign in_map_x = s_tdata[MAP_W-1:0];
    assign in_map_y = s_tdata[2*MAP_W-1:MAP_W];
    assign in_map_z = s_tdata[2*MAP_W+Z_W-1:2*MAP_W];

    assign b_ready = !b_valid_reg || rx_in_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_tready = coef_ready && a_ready;
    assign s_accept = s_tvalid && s_tready;

    // Scale and center stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_accept;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Stage A: scale column and row by zoom, height by the Q8.8 factor.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            xa_reg <= in_map_x * zoom_reg;
            ya_reg <= in_map_y * zoom_reg;
            za_reg <= in_map_z * $signed({1'b0, z_zoom_reg});
        end
    end

    // Stage B: subtract the map center and drop the height fraction toward zero.
    always_comb begin
        xa_ext = CW'(xa_reg);
        ya_ext = CW'(ya_reg);
        cx_ext = CW'(center_x_reg);
        cy_ext = CW'(center_y_reg);
        z_bias = za_reg[ZP_W-1] ? ZP_W'(255) : '0;
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            xb_reg <= xa_ext - cx_ext;
            yb_reg <= ya_ext - cy_ext;
            zb_reg <= CW'((za_reg + z_bias) >>> 8);
        end
    end

    // Rotation about x: p = y, q = z.
    prp_rotate #(.FRACTION_BITS(FRACTION_BITS)) u_rot_x (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(b_valid_reg),
        .in_ready(rx_in_ready),
        .in_p(yb_reg),
        .in_q(zb_reg),
        .in_side(xb_reg),
        .coef_c(cos_x),
        .coef_s(sin_x),
        .out_valid(rx_valid),
        .out_ready(ry_ready),
        .out_a(rx_y),
        .out_b(rx_z),
        .out_side(rx_x)
    );

    // Rotation about y: p = z, q = x, giving z then x.
    prp_rotate #(.FRACTION_BITS(FRACTION_BITS)) u_rot_y (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(rx_valid),
        .in_ready(ry_ready),
        .in_p(rx_z),
        .in_q(rx_x),
        .in_side(rx_y),
        .coef_c(cos_y),
        .coef_s(sin_y),
        .out_valid(ry_valid),
        .out_ready(rz_ready),
        .out_a(ry_z),
        .out_b(ry_x),
        .out_side(ry_y)
    );

    // Rotation about z: p = x, q = y.
    prp_rotate #(.FRACTION_BITS(FRACTION_BITS)) u_rot_z (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(ry_valid),
        .in_ready(rz_ready),
        .in_p(ry_x),
        .in_q(ry_y),
        .in_side(ry_z),
        .coef_c(cos_z),
        .coef_s(sin_z),
        .out_valid(rz_valid),
        .out_ready(pj_ready),
        .out_a(rz_x),
        .out_b(rz_y),
        .out_side(rz_z)
    );

    // Projection, screen shift and output register.
    prp_project #(.FRACTION_BITS(FRACTION_BITS)) u_project (
        .aclk(aclk),
        .aresetn(aresetn),
        .iso_mode(iso_mode_reg),
        .screen_x(screen_x_reg),
        .screen_y(screen_y_reg),
        .in_valid(rz_valid),
        .in_ready(pj_ready),
        .in_x(rz_x),
        .in_y(rz_y),
        .in_z(rz_z),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_x(out_x),
        .out_y(out_y),
        .out_z(out_z)
    );

    assign m_tdata = {{(M_DATA_W - 3 * OUT_W){1'b0}}, out_z, out_y, out_x};

endmodule

// File: sv/prp_trig.sv
// Sine and cosine tables and the sweep that loads the three axis coefficients.
// Uses prp_pkg; the tables are built at elaboration from SINE_STEPS and FRACTION_BITS.
module prp_trig #(
    parameter int SINE_STEPS = 1024,
    parameter int FRACTION_BITS = 14
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [prp_pkg::ANGLES_W-1:0]           angles,
    input  logic                                   angles_wr,
    output logic                                   coef_ready,
    output logic signed [FRACTION_BITS+1:0]        sin_x,
    output logic signed [FRACTION_BITS+1:0]        cos_x,
    output logic signed [FRACTION_BITS+1:0]        sin_y,
    output logic signed [FRACTION_BITS+1:0]        cos_y,
    output logic signed [FRACTION_BITS+1:0]        sin_z,
    output logic signed [FRACTION_BITS+1:0]        cos_z
);
    import prp_pkg::*;

    localparam int CFW = FRACTION_BITS + 2;
    localparam int RND_SH = 30 - FRACTION_BITS;
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned FULL_TURN = 4 * SINE_STEPS;
    localparam longint unsigned SIN_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint unsigned COS_DIV [1:7] = '{2, 12, 30, 56, 90, 132, 182};

    typedef logic signed [CFW-1:0] rom_t [ANGLE_DEPTH];

    // Sine of u quarter turns over SINE_STEPS, rounded half away from zero.
    function automatic longint sine_entry(input longint unsigned u);
        longint unsigned uu, q, r, a, ts, tc, mag;
        longint s, c, v;
        int k;
        uu = u % FULL_TURN;
        q = uu / SINE_STEPS;
        r = uu % SINE_STEPS;
        a = HALF_PI_Q30 * r / SINE_STEPS;
        ts = a;
        tc = Q30_ONE;
        s = longint'(a);
        c = longint'(Q30_ONE);
        for (k = 1; k <= 7; k++) begin
            ts = (((ts * a) >> 30) * a) >> 30;
            ts = ts / SIN_DIV[k];
            tc = (((tc * a) >> 30) * a) >> 30;
            tc = tc / COS_DIV[k];
            if (k % 2 == 1) begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end else begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        case (q)
            0: v = s;
            1: v = c;
            2: v = -s;
            default: v = -c;
        endcase
        mag = longint'(v < 0 ? -v : v);
        mag = (mag + (64'd1 << (RND_SH - 1))) >> RND_SH;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic rom_t build_rom(input logic cos_sel);
        rom_t rom;
        int i;
        for (i = 0; i < ANGLE_DEPTH; i++) begin
            rom[i] = CFW'(sine_entry(longint'(4 * i) + (cos_sel ? longint'(SINE_STEPS) : 0)));
        end
        return rom;
    endfunction

    localparam rom_t SIN_ROM = build_rom(1'b0);
    localparam rom_t COS_ROM = build_rom(1'b1);

    trig_state_t state_reg, state_next;
    logic [ANG_W-1:0] addr;
    logic signed [CFW-1:0] sin_rd_reg, cos_rd_reg;
    logic signed [CFW-1:0] sin_x_reg, cos_x_reg, sin_y_reg, cos_y_reg, sin_z_reg, cos_z_reg;

    // Sweep state register; reset and an angle write both start a reload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TRIG_READ_X;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and the table address of the axis being read.
    always_comb begin
        state_next = state_reg;
        addr = angles[ANG_W-1:0];
        case (state_reg)
            TRIG_READ_X: begin
                state_next = TRIG_READ_Y;
            end
            TRIG_READ_Y: begin
                addr = angles[2*ANG_W-1:ANG_W];
                state_next = TRIG_READ_Z;
            end
            TRIG_READ_Z: begin
                addr = angles[3*ANG_W-1:2*ANG_W];
                state_next = TRIG_LAST;
            end
            TRIG_LAST: begin
                state_next = TRIG_DONE;
            end
            TRIG_DONE: begin
                state_next = TRIG_DONE;
            end
            default: begin
                state_next = TRIG_READ_X;
            end
        endcase
        if (angles_wr) begin
            state_next = TRIG_READ_X;
        end
    end

    // Registered table read.
    always_ff @(posedge aclk) begin
        sin_rd_reg <= SIN_ROM[addr];
        cos_rd_reg <= COS_ROM[addr];
    end

    // Capture the data read in the previous cycle for its axis.
    always_ff @(posedge aclk) begin
        case (state_reg)
            TRIG_READ_Y: begin
                sin_x_reg <= sin_rd_reg;
                cos_x_reg <= cos_rd_reg;
            end
            TRIG_READ_Z: begin
                sin_y_reg <= sin_rd_reg;
                cos_y_reg <= cos_rd_reg;
            end
            TRIG_LAST: begin
                sin_z_reg <= sin_rd_reg;
                cos_z_reg <= cos_rd_reg;
            end
            default: begin
            end
        endcase
    end

    assign coef_ready = (state_reg == TRIG_DONE);
    assign sin_x = sin_x_reg;
    assign cos_x = cos_x_reg;
    assign sin_y = sin_y_reg;
    assign cos_y = cos_y_reg;
    assign sin_z = sin_z_reg;
    assign cos_z = cos_z_reg;

endmodule

// File: sv/prp_rotate.sv
// Two-stage plane rotation: a = trunc(p*c - q*s), b = trunc(p*s + q*c).
// Uses prp_pkg; one instance serves each of the three axes.
module prp_rotate #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [prp_pkg::CW-1:0]          in_p,
    input  logic signed [prp_pkg::CW-1:0]          in_q,
    input  logic signed [prp_pkg::CW-1:0]          in_side,
    input  logic signed [FRACTION_BITS+1:0]        coef_c,
    input  logic signed [FRACTION_BITS+1:0]        coef_s,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [prp_pkg::CW-1:0]          out_a,
    output logic signed [prp_pkg::CW-1:0]          out_b,
    output logic signed [prp_pkg::CW-1:0]          out_side
);
    import prp_pkg::*;

    localparam int PW = CW + FRACTION_BITS + 2;

    logic v1_reg, v2_reg, rdy1, rdy2;
    logic signed [PW-1:0] pc_reg, qs_reg, ps_reg, qc_reg;
    logic signed [CW-1:0] side1_reg, side2_reg, a_reg, b_reg;
    logic signed [PW:0] diff, sum;

    // Divide by 2^FRACTION_BITS, rounding toward zero.
    function automatic logic signed [CW-1:0] trunc_frac(input logic signed [PW:0] v);
        logic signed [PW:0] bias;
        bias = v[PW] ? {{(PW + 1 - FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}} : '0;
        return CW'((v + bias) >>> FRACTION_BITS);
    endfunction

    assign rdy2 = !v2_reg || out_ready;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // First stage: the four products.
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            pc_reg <= in_p * coef_c;
            qs_reg <= in_q * coef_s;
            ps_reg <= in_p * coef_s;
            qc_reg <= in_q * coef_c;
            side1_reg <= in_side;
        end
    end

    // Second stage: exact sums, then one truncation each.
    always_comb begin
        diff = pc_reg - qs_reg;
        sum = ps_reg + qc_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            a_reg <= trunc_frac(diff);
            b_reg <= trunc_frac(sum);
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_a = a_reg;
    assign out_b = b_reg;
    assign out_side = side2_reg;

endmodule

// File: sv/prp_project.sv
// Isometric projection, screen shift and saturation, ending in the output register.
// Uses prp_pkg; four pipeline stages with per-stage valid bits.
module prp_project #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   iso_mode,
    input  logic signed [prp_pkg::SCR_W-1:0]       screen_x,
    input  logic signed [prp_pkg::SCR_W-1:0]       screen_y,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [prp_pkg::CW-1:0]          in_x,
    input  logic signed [prp_pkg::CW-1:0]          in_y,
    input  logic signed [prp_pkg::CW-1:0]          in_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [prp_pkg::OUT_W-1:0]              out_x,
    output logic [prp_pkg::OUT_W-1:0]              out_y,
    output logic [prp_pkg::OUT_W-1:0]              out_z
);
    import prp_pkg::*;

    localparam int ISO_SH = 30 - FRACTION_BITS;
    localparam longint unsigned ISO_COS_Q30 = 64'd929887698;
    localparam logic signed [FRACTION_BITS:0] ISO_K =
        (FRACTION_BITS + 1)'((ISO_COS_Q30 + (64'd1 << (ISO_SH - 1))) >> ISO_SH);
    localparam int KP_W = CW + FRACTION_BITS + 1;
    localparam logic signed [CW:0] SAT_HI = (CW + 1)'(OUT_MAX);
    localparam logic signed [CW:0] SAT_LO = -SAT_HI - 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic signed [CW-1:0] d1_reg, e1_reg, x1_reg, y1_reg, z1_reg;
    logic signed [KP_W-1:0] kp2_reg;
    logic signed [CW-1:0] eh2_reg, x2_reg, y2_reg, z2_reg;
    logic signed [CW-1:0] x3_reg, y3_reg, z3_reg;
    logic [OUT_W-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [CW-1:0] e_bias, e_half;
    logic signed [KP_W-1:0] kp_bias;
    logic signed [CW-1:0] x_iso;
    logic signed [CW:0] x_sum, y_sum, z_ext;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [CW:0] v);
        logic signed [CW:0] t;
        t = v;
        if (v > SAT_HI) begin
            t = SAT_HI;
        end
        if (v < SAT_LO) begin
            t = SAT_LO;
        end
        return t[OUT_W-1:0];
    endfunction

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: difference x - y for the new x and x + y - 2z for the new y.
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            d1_reg <= in_x - in_y;
            e1_reg <= in_x + in_y - (in_z <<< 1);
            x1_reg <= in_x;
            y1_reg <= in_y;
            z1_reg <= in_z;
        end
    end

    // Stage 2: scale by cos(30 degrees) and halve toward zero.
    always_comb begin
        e_bias = {{(CW - 1){1'b0}}, e1_reg[CW-1]};
        e_half = (e1_reg + e_bias) >>> 1;
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            kp2_reg <= d1_reg * ISO_K;
            eh2_reg <= e_half;
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            z2_reg <= z1_reg;
        end
    end

    // Stage 3: truncate the scaled difference and pick the projection.
    always_comb begin
        kp_bias = kp2_reg[KP_W-1] ?
            {{(KP_W - FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}} : '0;
        x_iso = CW'((kp2_reg + kp_bias) >>> FRACTION_BITS);
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            x3_reg <= iso_mode ? x_iso : x2_reg;
            y3_reg <= iso_mode ? eh2_reg : y2_reg;
            z3_reg <= z2_reg;
        end
    end

    // Stage 4: screen shift and saturation into the output register.
    always_comb begin
        x_sum = x3_reg + screen_x;
        y_sum = y3_reg + screen_y;
        z_ext = z3_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            ox_reg <= sat_out(x_sum);
            oy_reg <= sat_out(y_sum);
            oz_reg <= sat_out(z_ext);
        end
    end

    assign out_valid = v4_reg;
    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign out_z = oz_reg;

endmodule
